### rtl/core/assert_macros.svh
// Assertion macros shared by the skinning core RTL.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/core/lbs_pkg.sv
// Shared types, widths and codes for the 2D linear blend skinning core.
// No dependencies; used by lbs_mul and the core top level.
`timescale 1ns / 1ps

package lbs_pkg;

  // Field widths
  localparam int DATA_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int OP_W     = 2;
  localparam int BONE_W   = 8;
  localparam int COUNT_W  = 9;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_BONE_COUNT = 1'b0;

  // Bone table depth default
  localparam int MAX_BONES_DEF = 256;

  // Datapath widths
  localparam int FRAC_W = 16;   // Q16.16 fraction bits
  localparam int WFRAC_W = 15;  // Q1.15 weight fraction bits
  localparam int XF_W   = 49;   // transformed coordinate, below 2^48 in magnitude
  localparam int LO_W   = 24;   // low split of a transformed coordinate
  localparam int ACC_W  = 64;   // running sums and weighted products
  localparam int MUL_W  = 33;   // shared multiplier operand width
  localparam int PROD_W = 66;   // shared multiplier product width

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd32768;
  localparam logic signed [ACC_W-1:0] SUM_LIMIT = 64'sh4000_0000_0000_0000;

  // Multiply sequence
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_RIGID_END = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TERM_END  = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TERM  = 2'd1,
    OP_RIGID = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // One bone table entry as stored in memory
  typedef struct packed {
    logic signed [DATA_W-1:0] xx;
    logic signed [DATA_W-1:0] xy;
    logic signed [DATA_W-1:0] yx;
    logic signed [DATA_W-1:0] yy;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
  } bone_t;

endpackage

### rtl/core/lbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/core/lbs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on lbs_pkg for operand and product widths.
`timescale 1ns / 1ps

module lbs_mul (
  input  logic                                clk,
  input  logic signed [lbs_pkg::MUL_W-1:0]    op_a,
  input  logic signed [lbs_pkg::MUL_W-1:0]    op_b,
  output logic signed [lbs_pkg::PROD_W-1:0]   prod_r
);

  logic signed [lbs_pkg::PROD_W-1:0] prod_nxt;

  // Full-width signed product
  assign prod_nxt = lbs_pkg::PROD_W'(op_a) * lbs_pkg::PROD_W'(op_b);

  // Register the product before any use
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/core/linear_blend_skinning_2d_core.sv
// 2D linear blend skinning core: bone table in RAM, one shared 33x33 multiplier.
// Depends on lbs_pkg, lbs_ram, lbs_mul and assert_macros.svh.
//
// A load word writes one bone entry if its index is below MAX_BONES. A
// weighted-term word with a present bone stalls the input through the multiply
// and accumulate states, a last term also through the emit state that emits
// the blended sum; a present-bone rigid word stalls through the multiply and
// emit states, and a missing-bone rigid word or last term only through emit.
// The single shared multiplier runs eight products per term in sequence: four
// matrix products, then the weight product of each coordinate split into two
// halves. The bone table has no reset and no clearing pass; reading a bone
// that was never loaded gives undefined coordinates. A finished result sits in
// the output register so the next word can be taken while it waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_blend_skinning_2d_core #(
  parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lbs_pkg::CFG_AW-1:0]           paddr,
  input  logic [lbs_pkg::CFG_DW-1:0]           pwdata,
  output logic [lbs_pkg::CFG_DW-1:0]           prdata,
  output logic                                 pready,

  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lbs_pkg::OP_W-1:0]             in_operation,
  input  logic [lbs_pkg::BONE_W-1:0]           in_bone_index,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_coef_xx,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_coef_xy,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_coef_yx,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_coef_yy,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_trans_x,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_trans_y,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_point_x,
  input  logic signed [lbs_pkg::DATA_W-1:0]    in_point_y,
  input  logic [lbs_pkg::WEIGHT_W-1:0]         in_weight,
  input  logic                                 in_last_term,

  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lbs_pkg::DATA_W-1:0]    out_deformed_x,
  output logic signed [lbs_pkg::DATA_W-1:0]    out_deformed_y,
  output logic                                 out_bone_missing,
  output logic                                 out_overflow
);

  localparam int AW     = $clog2(MAX_BONES);
  localparam int DATA_W = lbs_pkg::DATA_W;
  localparam int XF_W   = lbs_pkg::XF_W;
  localparam int ACC_W  = lbs_pkg::ACC_W;
  localparam int MUL_W  = lbs_pkg::MUL_W;
  localparam int LO_W   = lbs_pkg::LO_W;
  localparam int WT_W   = lbs_pkg::WEIGHT_W;

  localparam logic signed [ACC_W:0]   SUM_HI  = (ACC_W + 1)'(lbs_pkg::SUM_LIMIT);
  localparam logic signed [ACC_W:0]   SUM_LO  = -SUM_HI;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 64'sd1;

  // Clamp a grown sum back to the running-sum range
  function automatic logic signed [ACC_W-1:0] clamp_sum(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] res;
    if (v > SUM_HI) begin
      res = lbs_pkg::SUM_LIMIT;
    end else if (v < SUM_LO) begin
      res = -lbs_pkg::SUM_LIMIT;
    end else begin
      res = v[ACC_W-1:0];
    end
    return res;
  endfunction

  // Saturate to Q16.16; the top bit of the result flags saturation
  function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [DATA_W:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, SAT_MAX[DATA_W-1:0]};
    end else if (v < SAT_MIN) begin
      res = {1'b1, SAT_MIN[DATA_W-1:0]};
    end else begin
      res = {1'b0, v[DATA_W-1:0]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [lbs_pkg::COUNT_W-1:0] bone_count_r;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == lbs_pkg::REG_BONE_COUNT);
  assign prdata    = (paddr[2] == lbs_pkg::REG_BONE_COUNT) ?
                     lbs_pkg::CFG_DW'(bone_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= '0;
    end else if (cfg_write) begin
      bone_count_r <= pwdata[lbs_pkg::COUNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  lbs_pkg::state_t state_r, state_nxt;
  logic [lbs_pkg::STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [ACC_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;

  lbs_pkg::op_t             op_r;
  logic [AW-1:0]            bone_r;
  logic signed [DATA_W-1:0] px_r, py_r;
  logic [WT_W-1:0]          w_r;
  logic                     last_r, present_r;

  logic signed [XF_W-1:0]  tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [ACC_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt;

  logic signed [DATA_W-1:0] res_x_r, res_y_r;
  logic                     res_missing_r, res_ovf_r;

  // Input decode
  lbs_pkg::op_t    in_op;
  logic            in_accept;
  logic            in_present;
  logic            in_in_range;
  logic [WT_W-1:0] in_w_sat;

  assign in_op       = lbs_pkg::op_t'(in_operation);
  assign in_stall    = (state_r != lbs_pkg::ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign in_in_range = (32'(in_bone_index) < 32'(MAX_BONES));
  assign in_present  = in_in_range && (32'(in_bone_index) < 32'(bone_count_r));
  assign in_w_sat    = (in_weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : in_weight;

  // ---------------------------------------------------------------------------
  // Bone table
  // ---------------------------------------------------------------------------
  lbs_pkg::bone_t  wr_entry, rd_entry;
  logic            tbl_we;
  logic [AW-1:0]   tbl_raddr;

  assign wr_entry.xx = in_coef_xx;
  assign wr_entry.xy = in_coef_xy;
  assign wr_entry.yx = in_coef_yx;
  assign wr_entry.yy = in_coef_yy;
  assign wr_entry.sx = in_trans_x;
  assign wr_entry.sy = in_trans_y;

  assign tbl_we = in_accept && (in_op == lbs_pkg::OP_LOAD) && in_in_range;

  // Follow the input while idle, then hold the latched bone
  assign tbl_raddr = (state_r == lbs_pkg::ST_IDLE) ? AW'(in_bone_index) : bone_r;

  lbs_ram #(
    .WIDTH ($bits(lbs_pkg::bone_t)),
    .DEPTH (MAX_BONES)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (AW'(in_bone_index)),
    .wdata   (wr_entry),
    .raddr   (tbl_raddr),
    .rdata_r (rd_entry)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier and operand select
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0]          mul_a, mul_b, w_op;
  logic signed [lbs_pkg::PROD_W-1:0] prod_r;

  assign w_op = $signed({{(MUL_W - WT_W){1'b0}}, w_r});

  always_comb begin
    unique case (step_r)
      4'd0: begin
        mul_a = MUL_W'(rd_entry.xx);
        mul_b = MUL_W'(px_r);
      end
      4'd1: begin
        mul_a = MUL_W'(rd_entry.xy);
        mul_b = MUL_W'(py_r);
      end
      4'd2: begin
        mul_a = MUL_W'(rd_entry.yx);
        mul_b = MUL_W'(px_r);
      end
      4'd3: begin
        mul_a = MUL_W'(rd_entry.yy);
        mul_b = MUL_W'(py_r);
      end
      4'd4: begin
        mul_a = $signed({{(MUL_W - LO_W){1'b0}}, tx_r[LO_W-1:0]});
        mul_b = w_op;
      end
      4'd5: begin
        mul_a = MUL_W'($signed(tx_r[XF_W-1:LO_W]));
        mul_b = w_op;
      end
      4'd6: begin
        mul_a = $signed({{(MUL_W - LO_W){1'b0}}, ty_r[LO_W-1:0]});
        mul_b = w_op;
      end
      4'd7: begin
        mul_a = MUL_W'($signed(ty_r[XF_W-1:LO_W]));
        mul_b = w_op;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lbs_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic signed [XF_W-1:0]  mat_term;
  logic signed [XF_W-1:0]  term_x, term_y;
  logic                    slot_free;
  logic                    emit_fire;
  logic signed [ACC_W-1:0] src_x, src_y;
  logic [DATA_W:0]         sat_x, sat_y;

  assign mat_term  = XF_W'(prod_r >>> lbs_pkg::FRAC_W);
  assign term_x    = XF_W'(wx_r >>> lbs_pkg::WFRAC_W);
  assign term_y    = XF_W'(wy_r >>> lbs_pkg::WFRAC_W);
  assign slot_free = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == lbs_pkg::ST_EMIT) && slot_free;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    wx_nxt    = wx_r;
    wy_nxt    = wy_r;

    unique case (state_r)
      lbs_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_accept) begin
          unique case (in_op)
            lbs_pkg::OP_TERM: begin
              if (in_present) begin
                state_nxt = lbs_pkg::ST_MUL;
              end else if (in_last_term) begin
                state_nxt = lbs_pkg::ST_EMIT;
              end
            end
            lbs_pkg::OP_RIGID: begin
              state_nxt = in_present ? lbs_pkg::ST_MUL : lbs_pkg::ST_EMIT;
            end
            lbs_pkg::OP_LOAD, lbs_pkg::OP_NONE: begin
              state_nxt = lbs_pkg::ST_IDLE;
            end
            default: begin
              state_nxt = lbs_pkg::ST_IDLE;
            end
          endcase
        end
      end

      lbs_pkg::ST_MUL: begin
        // Load the translation, then fold in the product issued one step earlier
        unique case (step_r)
          4'd0: begin
            tx_nxt = XF_W'(rd_entry.sx);
            ty_nxt = XF_W'(rd_entry.sy);
          end
          4'd1, 4'd2: tx_nxt = tx_r + mat_term;
          4'd3, 4'd4: ty_nxt = ty_r + mat_term;
          4'd5: wx_nxt = ACC_W'(prod_r);
          4'd6: wx_nxt = wx_r + ACC_W'(prod_r <<< LO_W);
          4'd7: wy_nxt = ACC_W'(prod_r);
          4'd8: wy_nxt = wy_r + ACC_W'(prod_r <<< LO_W);
          default: begin
            tx_nxt = tx_r;
          end
        endcase
        step_nxt = step_r + 1'b1;
        if (op_r == lbs_pkg::OP_RIGID && step_r == lbs_pkg::STEP_RIGID_END) begin
          state_nxt = lbs_pkg::ST_EMIT;
        end else if (step_r == lbs_pkg::STEP_TERM_END) begin
          state_nxt = lbs_pkg::ST_ACC;
        end
      end

      lbs_pkg::ST_ACC: begin
        // Add the weighted term and clamp
        sum_x_nxt = clamp_sum((ACC_W + 1)'(sum_x_r) + (ACC_W + 1)'(term_x));
        sum_y_nxt = clamp_sum((ACC_W + 1)'(sum_y_r) + (ACC_W + 1)'(term_y));
        state_nxt = last_r ? lbs_pkg::ST_EMIT : lbs_pkg::ST_IDLE;
      end

      lbs_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = lbs_pkg::ST_IDLE;
          if (op_r == lbs_pkg::OP_TERM) begin
            sum_x_nxt = '0;
            sum_y_nxt = '0;
          end
        end
      end

      default: begin
        state_nxt = lbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Result source: blended sum, transformed point, or rest position
  always_comb begin
    if (op_r == lbs_pkg::OP_TERM) begin
      src_x = sum_x_r;
      src_y = sum_y_r;
    end else if (present_r) begin
      src_x = ACC_W'(tx_r);
      src_y = ACC_W'(ty_r);
    end else begin
      src_x = ACC_W'(px_r);
      src_y = ACC_W'(py_r);
    end
  end

  assign sat_x = sat32(src_x);
  assign sat_y = sat32(src_y);

  // Output word valid: set on emit, drop when taken
  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbs_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r      <= in_op;
      bone_r    <= AW'(in_bone_index);
      px_r      <= in_point_x;
      py_r      <= in_point_y;
      w_r       <= in_w_sat;
      last_r    <= in_last_term;
      present_r <= in_present;
    end
  end

  // Working coordinates and weighted products
  always_ff @(posedge clk) begin
    tx_r <= tx_nxt;
    ty_r <= ty_nxt;
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      res_x_r       <= sat_x[DATA_W-1:0];
      res_y_r       <= sat_y[DATA_W-1:0];
      res_missing_r <= (op_r == lbs_pkg::OP_RIGID) && !present_r;
      res_ovf_r     <= sat_x[DATA_W] || sat_y[DATA_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_deformed_x   = res_x_r;
  assign out_deformed_y   = res_y_r;
  assign out_bone_missing = res_missing_r;
  assign out_overflow     = res_ovf_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_step_bound, state_r == lbs_pkg::ST_MUL, step_r <= lbs_pkg::STEP_TERM_END)
  `ASSERT_NEXT(a_emit_only, state_r != lbs_pkg::ST_EMIT && !out_valid_r, !out_valid_r)
  `ASSERT_NEXT(a_emit_done, emit_fire, state_r == lbs_pkg::ST_IDLE && out_valid_r)
  `ASSERT_IMPLIES(a_sum_bound, 1'b1, sum_x_r <= lbs_pkg::SUM_LIMIT && sum_x_r >= -lbs_pkg::SUM_LIMIT && sum_y_r <= lbs_pkg::SUM_LIMIT && sum_y_r >= -lbs_pkg::SUM_LIMIT)

endmodule
